// File: rtl/dtl_pkg.sv
// ----------------------------------------------------------------------------
// dtl_pkg
// Types, widths and constants shared by the drop-tail link timing block.
// ----------------------------------------------------------------------------
package dtl_pkg;

   localparam int NOW_W      = 48;
   localparam int LEN_W      = 16;
   localparam int DRAW_W     = 16;
   localparam int VERDICT_W  = 2;
   localparam int CFG_W      = 32;
   localparam int THRESH_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Wire time numerator: (65535 + 32) * 1000000 stays below 2^36.
   localparam int NUM_W = 36;
   localparam int DEN_W = 32;
   localparam int CNT_W = $clog2(NUM_W + 1);

   localparam logic [LEN_W:0]     OVERHEAD_BYTES = (LEN_W + 1)'(32);
   localparam logic [19:0]        US_PER_SEC     = 20'd1000000;
   localparam logic [NOW_W-1:0]   FINISH_MAX     = {NOW_W{1'b1}};

   localparam logic [CFG_W-1:0]    DELAY_RESET  = '0;
   localparam logic [CFG_W-1:0]    QLIMIT_RESET = '0;
   localparam logic [CFG_W-1:0]    RATE_RESET   = CFG_W'(125000);
   localparam logic [THRESH_W-1:0] THRESH_RESET = '0;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_SCHEDULED = 2'd0,
      VERDICT_LOST      = 2'd1,
      VERDICT_TAILDROP  = 2'd2
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY  = 2'd0,
      CSR_QLIMIT = 2'd1,
      CSR_RATE   = 2'd2,
      CSR_THRESH = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_DROP,
      ST_DIV,
      ST_SUM,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: rtl/dtl_if.sv
// ----------------------------------------------------------------------------
// dtl_if
// Valid/ready channels of the drop-tail link timing block.
// ----------------------------------------------------------------------------
interface dtl_req_if import dtl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NOW_W-1:0]  now_us;
   logic [LEN_W-1:0]  payload_bytes;
   logic [DRAW_W-1:0] loss_draw;

   modport source (output valid, now_us, payload_bytes, loss_draw, input ready);
   modport sink   (input valid, now_us, payload_bytes, loss_draw, output ready);
endinterface

interface dtl_rsp_if import dtl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic [NOW_W-1:0]     finish_us;

   modport source (output valid, verdict, finish_us, input ready);
   modport sink   (input valid, verdict, finish_us, output ready);
endinterface

interface dtl_csr_if import dtl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/drop_tail_link_timing.sv
// Order: an accepted packet passes the prepare and check states; a lost packet then goes
// to the finish state, a tail-dropped one through the drop state, and a scheduled one
// through the drop, divide and sum states; a waiting result adds its stall time.
// One packet is handled at a time; the serial wire-time divider is its longest step.
// Reset: synchronous, clears the link finish time to zero and loads the
// register defaults (rate 125000 bytes per second, all others zero).
// ----------------------------------------------------------------------------
// drop_tail_link_timing
// Per-packet timing of one direction of an emulated drop-tail link.
// ----------------------------------------------------------------------------
module drop_tail_link_timing import dtl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   dtl_req_if.sink  req,
   dtl_rsp_if.source rsp,
   dtl_csr_if.sink  csr
);

   // Configuration registers
   logic [CFG_W-1:0]    delay_ff;
   logic [CFG_W-1:0]    qlimit_ff;
   logic [CFG_W-1:0]    rate_ff;
   logic [THRESH_W-1:0] thresh_ff;

   // Link state
   logic [NOW_W-1:0] last_finish_ff;

   // Packet datapath
   logic [NOW_W-1:0]  now_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic [NOW_W:0]    nominal_ff;
   logic              lost_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [NOW_W:0]    start_ff;
   logic [NOW_W-1:0]  wait_ff;
   verdict_type       verdict_ff;
   logic [NOW_W-1:0]  finish_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   logic [NOW_W-1:0]     rsp_finish_ff;

   state_type state_ff;
   state_type state_in;

   logic        req_take;
   logic        load_out;
   logic        div_start;
   logic        drop;
   logic        later;
   logic [LEN_W:0]    len_ext;
   logic [NUM_W:0]    product;
   logic [NOW_W+1:0]  finish_sum;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign req_take   = req.valid && req.ready;
   assign drop       = {{(NOW_W-CFG_W){1'b0}}, qlimit_ff} < wait_ff;
   assign later      = {1'b0, last_finish_ff} > nominal_ff;
   assign len_ext    = {1'b0, len_ff} + OVERHEAD_BYTES;
   assign product    = (NUM_W+1)'(len_ext) * (NUM_W+1)'(US_PER_SEC);
   assign finish_sum = (NOW_W+2)'(start_ff) + (NOW_W+2)'(div_rsp.quot);

   // A zero rate divides as one byte per second.
   assign div_req.start = div_start;
   assign div_req.num   = num_ff;
   assign div_req.den   = (rate_ff == '0) ? DEN_W'(1) : rate_ff;

   dtl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Register writes are always taken.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         qlimit_ff <= QLIMIT_RESET;
         rate_ff   <= RATE_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_DELAY:  delay_ff  <= csr.data;
            CSR_QLIMIT: qlimit_ff <= csr.data;
            CSR_RATE:   rate_ff   <= csr.data;
            CSR_THRESH: thresh_ff <= csr.data[THRESH_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req.ready = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = lost_ff ? ST_FIN : ST_DROP;
         end
         ST_DROP: begin
            if (drop) begin
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // The result register may still hold the previous transaction.
            if (!rsp_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff  <= req.now_us;
         len_ff  <= req.payload_bytes;
         draw_ff <= req.loss_draw;
      end
      if (state_ff == ST_PREP) begin
         nominal_ff <= (NOW_W+1)'(now_ff) + (NOW_W+1)'(delay_ff);
         lost_ff    <= (thresh_ff != '0) && ({1'b0, draw_ff} <= thresh_ff);
         num_ff     <= product[NUM_W-1:0];
      end
      if (state_ff == ST_CHECK) begin
         start_ff   <= later ? {1'b0, last_finish_ff} : nominal_ff;
         wait_ff    <= later ? NOW_W'({1'b0, last_finish_ff} - nominal_ff) : '0;
         verdict_ff <= VERDICT_LOST;
         finish_ff  <= '0;
      end
      if (state_ff == ST_DROP) begin
         verdict_ff <= drop ? VERDICT_TAILDROP : VERDICT_SCHEDULED;
      end
      if (state_ff == ST_SUM) begin
         finish_ff <= (finish_sum > (NOW_W+2)'(FINISH_MAX)) ?
                      FINISH_MAX : finish_sum[NOW_W-1:0];
      end
      if (load_out) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_finish_ff  <= finish_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         last_finish_ff <= '0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load_out && verdict_ff == VERDICT_SCHEDULED) begin
            last_finish_ff <= finish_ff;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.verdict   = rsp_verdict_ff;
   assign rsp.finish_us = rsp_finish_ff;

endmodule

// File: rtl/dtl_div.sv
// ----------------------------------------------------------------------------
// dtl_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtl_div import dtl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] work_ff;

   logic [DEN_W:0]   rem_shift;
   logic             fits;
   logic [DEN_W:0]   rem_diff;

   // The remainder is always below the divisor, so after the shift it
   // needs one extra bit and after the subtract it fits again.
   assign rem_shift = {rem_ff, work_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= '0;
         den_ff  <= div_req.den;
         work_ff <= div_req.num;
      end else if (busy_ff) begin
         rem_ff  <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         work_ff <= {work_ff[NUM_W-2:0], fits};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = work_ff;

endmodule

// File: rtl/dtl_chk.sv
// ----------------------------------------------------------------------------
// dtl_chk
// Port-level checks of the drop-tail link timing block, bound to its top level.
// ----------------------------------------------------------------------------
module dtl_chk import dtl_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [VERDICT_W-1:0] rsp_verdict,
   input logic [NOW_W-1:0]     rsp_finish_us
);

   // Finish time of the last scheduled packet seen at the result port.
   logic [NOW_W-1:0] sched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sched_ff <= '0;
      end else if (rsp_valid && rsp_ready && rsp_verdict == VERDICT_SCHEDULED) begin
         sched_ff <= rsp_finish_us;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_verdict) && $stable(rsp_finish_us))
      else $error("result changed while stalled");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_SCHEDULED |-> rsp_finish_us == '0)
      else $error("dropped packet carries a finish time");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new packet taken while one is in progress");

   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_SCHEDULED |-> rsp_finish_us >= sched_ff)
      else $error("link finish time moved backward");

endmodule

bind drop_tail_link_timing dtl_chk u_dtl_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_verdict   (rsp.verdict),
   .rsp_finish_us (rsp.finish_us)
);
